FILE: design/fha_pkg.sv
package fha_pkg;

  // Default sizing of the heap
  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int MAX_PAGES_DEF    = 64;
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 32;
  localparam int STATS_BYTES_DEF  = 16;

  // Fixed widths of the stream fields
  localparam int REQ_W   = 18;
  localparam int COUNT_W = 7;

  // Item kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_OOM = 2'd2
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [REQ_W-1:0]     granted_offset;
    logic [COUNT_W-1:0]   pages_in_use;
    logic [COUNT_W-1:0]   blocks_in_use;
  } fha_result_t;

endpackage

FILE: design/fha_mem.sv
module fha_mem import fha_pkg::*; #(
  parameter int DEPTH = MAX_BLOCKS_DEF,
  parameter int DW    = 39
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/fha_ctrl.sv
module fha_ctrl import fha_pkg::*; #(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int MAX_PAGES    = MAX_PAGES_DEF,
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int STATS_BYTES  = STATS_BYTES_DEF,
  localparam int W     = $clog2(PAGE_BYTES * MAX_PAGES + 1),
  localparam int DW    = 2 * W + 1,
  localparam int IDX_W = $clog2(MAX_BLOCKS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [REQ_W-1:0]  in_req,
  input  logic [REQ_W-1:0]  in_off,
  output logic              res_valid,
  input  logic              res_ready,
  output fha_result_t       res,
  output logic [IDX_W-1:0]  mem_rd_addr,
  input  logic [DW-1:0]     mem_rd_data,
  output logic              mem_wr_en,
  output logic [IDX_W-1:0]  mem_wr_addr,
  output logic [DW-1:0]     mem_wr_data
);

  localparam int CW    = ((W > REQ_W) ? W : REQ_W) + 2;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int PG_W  = $clog2(MAX_PAGES + 1);

  localparam logic [W-1:0]  PAGE_C  = W'(PAGE_BYTES);
  localparam logic [W-1:0]  HDR_C   = W'(HEADER_BYTES);
  localparam logic [CW-1:0] HDR_CW  = CW'(HEADER_BYTES);
  localparam logic [W-1:0]  STATS_C = W'(STATS_BYTES);

  typedef struct packed {
    logic [W-1:0] start;
    logic [W-1:0] len;
    logic         used;
  } entry_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_GROW, S_NEXT_RD, S_NEXT_CHK,
    S_MERGE, S_SHUP_RD, S_SHUP_WR, S_WR_A, S_WR_B, S_SHDN_RD, S_SHDN_WR,
    S_LAST_RD, S_LAST_CHK, S_SHRINK, S_WR_L, S_DONE
  } state_t;

  state_t              state;
  logic                kind;
  logic [REQ_W-1:0]    req;
  logic [REQ_W-1:0]    off;
  logic [CW-1:0]       need;
  logic [CNT_W-1:0]    total;
  logic [PG_W-1:0]     pages;
  logic [W-1:0]        top_addr;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    ridx;
  logic [CNT_W-1:0]    widx;
  entry_t              cur;
  entry_t              prev;
  entry_t              wa;
  entry_t              wb;
  logic [CNT_W-1:0]    aa;
  logic [CNT_W-1:0]    ab;
  logic                two;
  logic                nfree;
  logic [1:0]          drops;
  logic [CW-1:0]       len_t;
  logic [PG_W-1:0]     pages_t;
  logic [W-1:0]        end_t;
  status_t             status;
  logic [W-1:0]        granted;

  entry_t              rd_e;
  logic                fit;
  logic                is_last;
  logic                hit;

  assign rd_e    = entry_t'(mem_rd_data);
  assign fit     = !rd_e.used && (CW'(rd_e.len) >= CW'(req));
  assign is_last = ({1'b0, idx} + 1'b1) == {1'b0, total};
  assign hit     = (CW'(rd_e.start) + HDR_CW) == CW'(off);

  assign in_ready    = (state == S_IDLE);
  assign res_valid   = (state == S_DONE);
  assign mem_rd_addr = ridx[IDX_W-1:0];

  assign res.status         = status;
  assign res.granted_offset = REQ_W'(granted);
  assign res.pages_in_use   = COUNT_W'(pages);
  assign res.blocks_in_use  = COUNT_W'(total);

  // Drive the write port from the current state
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = aa[IDX_W-1:0];
    mem_wr_data = DW'(wa);
    unique case (state)
      S_INIT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = '0;
        mem_wr_data = DW'({STATS_C, PAGE_C - STATS_C - HDR_C, 1'b0});
      end
      S_WR_A, S_WR_L: begin
        mem_wr_en = 1'b1;
      end
      S_WR_B: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ab[IDX_W-1:0];
        mem_wr_data = DW'(wb);
      end
      S_SHUP_WR, S_SHDN_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = widx[IDX_W-1:0];
        mem_wr_data = mem_rd_data;
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      total    <= CNT_W'(1);
      pages    <= PG_W'(1);
      top_addr <= PAGE_C;
    end else begin
      unique case (state)
        // Table holds one free block after reset
        S_INIT: begin
          state <= S_IDLE;
        end

        S_IDLE: begin
          if (in_valid) begin
            kind    <= in_kind;
            req     <= in_req;
            off     <= in_off;
            need    <= CW'(in_req) + HDR_CW + CW'(1);
            granted <= '0;
            idx     <= '0;
            ridx    <= '0;
            if (in_kind == KIND_ALLOC && in_req == '0) begin
              status <= ST_BAD;
              state  <= S_DONE;
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end

        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end

        // Walk the table in address order
        S_SCAN_CHK: begin
          cur  <= rd_e;
          prev <= cur;
          if (kind == KIND_ALLOC) begin
            if ((fit && !is_last)) begin
              granted <= rd_e.start + HDR_C;
              status  <= ST_OK;
              if (CW'(rd_e.len) >= need && total < CNT_W'(MAX_BLOCKS)) begin
                wa    <= '{start: rd_e.start, len: W'(req), used: 1'b1};
                aa    <= idx;
                wb    <= '{start: rd_e.start + HDR_C + W'(req),
                           len: rd_e.len - W'(req) - HDR_C, used: 1'b0};
                ab    <= idx + 1'b1;
                two   <= 1'b1;
                widx  <= total;
                ridx  <= total - 1'b1;
                state <= S_SHUP_RD;
              end else begin
                wa    <= '{start: rd_e.start, len: rd_e.len, used: 1'b1};
                aa    <= idx;
                two   <= 1'b0;
                state <= S_WR_A;
              end
            end else if (is_last) begin
              if (total >= CNT_W'(MAX_BLOCKS)) begin
                status <= ST_OOM;
                state  <= S_DONE;
              end else begin
                len_t   <= CW'(rd_e.len);
                pages_t <= pages;
                end_t   <= top_addr;
                state   <= S_GROW;
              end
            end else begin
              idx   <= idx + 1'b1;
              ridx  <= idx + 1'b1;
              state <= S_SCAN_RD;
            end
          end else begin
            if (hit) begin
              if (!rd_e.used) begin
                status <= ST_BAD;
                state  <= S_DONE;
              end else if (is_last) begin
                nfree <= 1'b0;
                state <= S_MERGE;
              end else begin
                ridx  <= idx + 1'b1;
                state <= S_NEXT_RD;
              end
            end else if (is_last) begin
              status <= ST_BAD;
              state  <= S_DONE;
            end else begin
              idx   <= idx + 1'b1;
              ridx  <= idx + 1'b1;
              state <= S_SCAN_RD;
            end
          end
        end

        // Add pages to the last block until the split fits or the page limit is reached
        S_GROW: begin
          if (len_t >= need) begin
            pages    <= pages_t;
            top_addr <= end_t;
            status   <= ST_OK;
            granted  <= cur.start + HDR_C;
            wa       <= '{start: cur.start, len: W'(req), used: 1'b1};
            aa       <= idx;
            wb       <= '{start: cur.start + HDR_C + W'(req),
                          len: W'(len_t) - W'(req) - HDR_C, used: 1'b0};
            ab       <= idx + 1'b1;
            two      <= 1'b1;
            state    <= S_WR_A;
          end else if (pages_t == PG_W'(MAX_PAGES)) begin
            status <= ST_OOM;
            state  <= S_DONE;
          end else begin
            len_t   <= len_t + CW'(PAGE_C);
            pages_t <= pages_t + 1'b1;
            end_t   <= end_t + PAGE_C;
          end
        end

        S_NEXT_RD: begin
          state <= S_NEXT_CHK;
        end

        // Absorb a free right neighbor
        S_NEXT_CHK: begin
          nfree <= !rd_e.used;
          if (!rd_e.used) begin
            cur.len <= cur.len + HDR_C + rd_e.len;
          end
          state <= S_MERGE;
        end

        // Absorb a free left neighbor, or else mark the block free in place
        S_MERGE: begin
          status <= ST_OK;
          if (idx != '0 && !prev.used) begin
            wa    <= '{start: prev.start, len: prev.len + HDR_C + cur.len, used: 1'b0};
            aa    <= idx - 1'b1;
            drops <= 2'd1 + {1'b0, nfree};
          end else begin
            wa    <= '{start: cur.start, len: cur.len, used: 1'b0};
            aa    <= idx;
            drops <= {1'b0, nfree};
          end
          state <= S_WR_A;
        end

        // Open a slot by moving entries up, top first
        S_SHUP_RD: begin
          state <= S_SHUP_WR;
        end

        S_SHUP_WR: begin
          if (widx > idx + 2'd2) begin
            widx  <= widx - 1'b1;
            ridx  <= widx - 2'd2;
            state <= S_SHUP_RD;
          end else begin
            state <= S_WR_A;
          end
        end

        S_WR_A: begin
          if (kind == KIND_ALLOC) begin
            state <= two ? S_WR_B : S_DONE;
          end else if (drops != '0 &&
                       ({1'b0, aa} + 1'b1 + drops) < {1'b0, total}) begin
            widx  <= aa + 1'b1;
            ridx  <= CNT_W'({1'b0, aa} + 1'b1 + drops);
            state <= S_SHDN_RD;
          end else begin
            total <= total - CNT_W'(drops);
            ridx  <= total - CNT_W'(drops) - 1'b1;
            state <= S_LAST_RD;
          end
        end

        S_WR_B: begin
          total <= total + 1'b1;
          state <= S_DONE;
        end

        // Close the gap by moving entries down
        S_SHDN_RD: begin
          state <= S_SHDN_WR;
        end

        S_SHDN_WR: begin
          if (({1'b0, widx} + 1'b1 + drops) < {1'b0, total}) begin
            widx  <= widx + 1'b1;
            ridx  <= CNT_W'({1'b0, widx} + 1'b1 + drops);
            state <= S_SHDN_RD;
          end else begin
            total <= total - CNT_W'(drops);
            ridx  <= total - CNT_W'(drops) - 1'b1;
            state <= S_LAST_RD;
          end
        end

        S_LAST_RD: begin
          state <= S_LAST_CHK;
        end

        S_LAST_CHK: begin
          cur     <= rd_e;
          aa      <= ridx;
          end_t   <= top_addr;
          pages_t <= pages;
          len_t   <= CW'(rd_e.start) + HDR_CW + CW'(1);
          state   <= S_SHRINK;
        end

        // Release trailing pages one at a time
        S_SHRINK: begin
          if (pages_t > PG_W'(1) && CW'(end_t - PAGE_C) >= len_t) begin
            pages_t <= pages_t - 1'b1;
            end_t   <= end_t - PAGE_C;
          end else begin
            pages    <= pages_t;
            top_addr <= end_t;
            wa       <= '{start: cur.start, len: end_t - cur.start - HDR_C, used: 1'b0};
            state    <= S_WR_L;
          end
        end

        S_WR_L: begin
          state <= S_DONE;
        end

        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/first_fit_heap_allocator.sv
// Channel  Direction  Ports                       Contents
// s        in         s_tvalid s_tready s_tdata   request_bytes, payload_offset
//                     s_tuser                     kind
// m        out        m_tvalid m_tready m_tdata   status, granted_offset,
//                                                 pages_in_use, blocks_in_use
//
// One item at a time; the block table sits in a one-port-read memory.
// The table walk reads and checks entries in order up to the match; a split
// moves entries up and a merge moves them down, one entry at a time above the
// match; growth and page release go one page at a time.
// Reset is synchronous; the S_INIT state after reset writes the initial block.
// A result waits in the output register while the next item is accepted.
module first_fit_heap_allocator import fha_pkg::*; #(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int MAX_PAGES    = MAX_PAGES_DEF,
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int STATS_BYTES  = STATS_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // request_bytes[17:0], payload_offset[35:18]
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[1:0], granted_offset[19:2],
                                 // pages_in_use[26:20], blocks_in_use[33:27]
);

  localparam int W     = $clog2(PAGE_BYTES * MAX_PAGES + 1);
  localparam int DW    = 2 * W + 1;
  localparam int IDX_W = $clog2(MAX_BLOCKS);

  logic              res_valid;
  logic              res_ready;
  fha_result_t       res;
  logic [IDX_W-1:0]  rd_addr;
  logic [DW-1:0]     rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [DW-1:0]     wr_data;
  fha_result_t       out_r;

  fha_ctrl #(
    .PAGE_BYTES  (PAGE_BYTES),
    .MAX_PAGES   (MAX_PAGES),
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES),
    .STATS_BYTES (STATS_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_kind    (s_tuser),
    .in_req     (s_tdata[17:0]),
    .in_off     (s_tdata[35:18]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_rd_addr(rd_addr),
    .mem_rd_data(rd_data),
    .mem_wr_en  (wr_en),
    .mem_wr_addr(wr_addr),
    .mem_wr_data(wr_data)
  );

  fha_mem #(
    .DEPTH(MAX_BLOCKS),
    .DW   (DW)
  ) u_mem (
    .clk    (clk),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  assign res_ready = !m_tvalid || m_tready;

  // Hold the result until the sink takes the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign m_tdata = {6'd0, out_r.blocks_in_use, out_r.pages_in_use,
                    out_r.granted_offset, out_r.status};

endmodule

FILE: design/fha_checker.sv
module fha_checker import fha_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Heap never empties
  a_counts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[26:20] != 7'd0 && m_tdata[33:27] != 7'd0)
    else $error("page or block count is zero");

  // Failed items grant nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[19:2] == 18'd0)
    else $error("failed item carries an offset");

  // Status code in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("undefined status code");

  // One item in flight: drop ready right after an input transfer
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in flight");

endmodule

bind first_fit_heap_allocator fha_checker u_fha_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

FILE: tb/first_fit_heap_allocator_checker.sv
module first_fit_heap_allocator_checker import fha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  output int          failures,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE   = PAGE_BYTES_DEF;
  localparam int MAXP   = MAX_PAGES_DEF;
  localparam int MAXB   = MAX_BLOCKS_DEF;
  localparam int HDR    = HEADER_BYTES_DEF;
  localparam int STATS  = STATS_BYTES_DEF;

  // Shadow copy of the block table
  int shadow_start [MAXB];
  int heap_len   [MAXB];
  bit heap_used  [MAXB];
  int heap_blocks;
  int heap_pages;

  fha_result_t expected_results[$];

  function automatic void clear_heap();
    for (int j = 0; j < MAXB; j++) begin
      shadow_start[j] = 0;
      heap_len[j]   = 0;
      heap_used[j]  = 0;
    end
    shadow_start[0] = STATS;
    heap_len[0]   = PAGE - STATS - HDR;
    heap_blocks   = 1;
    heap_pages    = 1;
  endfunction

  // Carve req bytes off block i; the rest becomes a new free block
  function automatic void carve(int i, int req);
    int rest;
    rest = heap_len[i] - req - HDR;
    for (int j = heap_blocks; j > i + 1; j--) begin
      shadow_start[j] = shadow_start[j-1];
      heap_len[j]   = heap_len[j-1];
      heap_used[j]  = heap_used[j-1];
    end
    heap_blocks++;
    shadow_start[i+1] = shadow_start[i] + HDR + req;
    heap_len[i+1]   = rest;
    heap_used[i+1]  = 0;
    heap_len[i]     = req;
  endfunction

  function automatic void remove_entry(int i);
    for (int j = i; j + 1 < heap_blocks; j++) begin
      shadow_start[j] = shadow_start[j+1];
      heap_len[j]   = heap_len[j+1];
      heap_used[j]  = heap_used[j+1];
    end
    heap_blocks--;
  endfunction

  function automatic status_t allocate(int req, output int granted);
    int last, i, need, grow, len;
    granted = 0;
    if (req == 0) return ST_BAD;
    last = heap_blocks - 1;
    need = req + HDR + 1;
    for (i = 0; i < heap_blocks; i++)
      if (!heap_used[i] && heap_len[i] >= req) break;
    if (i >= last) begin
      len  = heap_len[last];
      grow = (len < need) ? (need - len + PAGE - 1) / PAGE : 0;
      if (heap_pages + grow > MAXP || heap_blocks >= MAXB) return ST_OOM;
      heap_len[last] = len + grow * PAGE;
      heap_pages += grow;
      carve(last, req);
      i = last;
    end else if (heap_len[i] >= need && heap_blocks < MAXB) begin
      carve(i, req);
    end
    heap_used[i] = 1;
    granted = shadow_start[i] + HDR;
    return ST_OK;
  endfunction

  function automatic status_t free_block(int off);
    int i, last, floor_end;
    for (i = 0; i < heap_blocks; i++)
      if (shadow_start[i] + HDR == off) break;
    if (i >= heap_blocks) return ST_BAD;
    if (!heap_used[i]) return ST_BAD;
    heap_used[i] = 0;
    if (i + 1 < heap_blocks && !heap_used[i+1]) begin
      heap_len[i] += HDR + heap_len[i+1];
      remove_entry(i + 1);
    end
    if (i > 0 && !heap_used[i-1]) begin
      heap_len[i-1] += HDR + heap_len[i];
      remove_entry(i);
    end
    // Give back trailing pages above the last block's floor
    last = heap_blocks - 1;
    floor_end = shadow_start[last] + HDR + 1;
    while (heap_pages > 1 && (heap_pages - 1) * PAGE >= floor_end) heap_pages--;
    heap_len[last] = heap_pages * PAGE - shadow_start[last] - HDR;
    return ST_OK;
  endfunction

  function automatic fha_result_t predict_heap(logic kind, int req, int off);
    fha_result_t r;
    int granted;
    if (kind == KIND_ALLOC) r.status = allocate(req, granted);
    else begin
      r.status = free_block(off);
      granted = 0;
    end
    r.granted_offset = (r.status == ST_OK) ? granted[REQ_W-1:0] : '0;
    r.pages_in_use   = heap_pages[COUNT_W-1:0];
    r.blocks_in_use  = heap_blocks[COUNT_W-1:0];
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    fha_result_t exp_r;
    logic [1:0] act_status;
    logic [REQ_W-1:0] act_granted;
    logic [COUNT_W-1:0] act_pages, act_blocks;
    int errs;
    errs = 0;
    if (rst) begin
      clear_heap();
      expected_results.delete();
      failures <= 0;
    end else begin
      // Compare an output transfer against the oldest prediction
      if (m_tvalid && m_tready) begin
        act_status  = m_tdata[1:0];
        act_granted = m_tdata[19:2];
        act_pages   = m_tdata[26:20];
        act_blocks  = m_tdata[33:27];
        if (expected_results.size() == 0) begin
          $error("result with no expected item: tdata=%h", m_tdata);
          errs++;
        end else begin
          exp_r = expected_results.pop_front();
          if (act_status != exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, act_status);
            errs++;
          end
          if (act_granted != exp_r.granted_offset) begin
            $error("granted_offset: expected %0d actual %0d",
                   exp_r.granted_offset, act_granted);
            errs++;
          end
          if (act_pages != exp_r.pages_in_use) begin
            $error("pages_in_use: expected %0d actual %0d",
                   exp_r.pages_in_use, act_pages);
            errs++;
          end
          if (act_blocks != exp_r.blocks_in_use) begin
            $error("blocks_in_use: expected %0d actual %0d",
                   exp_r.blocks_in_use, act_blocks);
            errs++;
          end
        end
      end
      if (errs != 0) failures <= failures + errs;
      // Predict the result of an input transfer
      if (s_tvalid && s_tready)
        expected_results.push_back(predict_heap(s_tuser, int'(s_tdata[17:0]),
                                                int'(s_tdata[35:18])));
    end
  end
endmodule

FILE: tb/first_fit_heap_allocator_tb.sv
module first_fit_heap_allocator_tb import fha_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_PCT = 8;
  localparam int IDLE_LIMIT = 5000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = KIND_ALLOC;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  int          failures;
  int          pending;
  bit          quiet = 0;
  int          idle_cycles = 0;

  // Offsets believed granted, and kinds sent awaiting their result
  int   live_offsets[$];
  logic sent_kinds[$];

  always #5 clk = ~clk;

  first_fit_heap_allocator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  first_fit_heap_allocator_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .failures(failures), .pending(pending)
  );

  // Random backpressure on the result side
  always @(negedge clk)
    if (!rst) m_tready <= quiet || ($urandom_range(0, 99) >= STALL_PCT);

  // Track granted offsets for later frees; watch for a hang
  always @(posedge clk) begin
    logic k;
    if (!rst) begin
      if (s_tvalid && s_tready) sent_kinds.push_back(s_tuser);
      if (m_tvalid && m_tready && sent_kinds.size() > 0) begin
        k = sent_kinds.pop_front();
        if (k == KIND_ALLOC && m_tdata[1:0] == ST_OK)
          live_offsets.push_back(int'(m_tdata[19:2]));
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_item(logic kind, int req, int off);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < STALL_PCT) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0, off[17:0], req[17:0]};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic int pick_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(1, 600);
    if (p < 90) return $urandom_range(601, 8000);
    if (p < 98) return $urandom_range(8001, 60000);
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 262143;
      default: return $urandom_range(0, 262143);
    endcase
  endfunction

  initial begin
    int idx, off;
    bit alloc;
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed: rejects, out of memory, double free, big growth and release
    send_item(KIND_ALLOC, 0, 0);
    send_item(KIND_ALLOC, 262143, 0);
    send_item(KIND_FREE, 0, 0);
    send_item(KIND_FREE, 0, 48);
    send_item(KIND_FREE, 0, 262143);
    send_item(KIND_ALLOC, 1, 262143);
    send_item(KIND_FREE, 262143, 48);
    send_item(KIND_FREE, 0, 48);
    send_item(KIND_ALLOC, 4048, 0);
    send_item(KIND_FREE, 0, 48);
    send_item(KIND_ALLOC, 200000, 0);
    send_item(KIND_ALLOC, 100000, 0);
    send_item(KIND_FREE, 0, 48);
    send_item(KIND_ALLOC, 4015, 0);
    send_item(KIND_ALLOC, 1, 0);
    send_item(KIND_FREE, 0, 48);
    send_item(KIND_ALLOC, 2000, 0);
    send_item(KIND_FREE, 0, 4095);

    // Random: phases alternate between filling and draining the heap
    for (int n = 0; n < 1150; n++) begin
      quiet = (n >= 400 && n < 600);
      alloc = $urandom_range(0, 99) < (((n / 150) % 2 == 0) ? 75 : 35);
      if (alloc) send_item(KIND_ALLOC, pick_size(), $urandom_range(0, 262143));
      else begin
        if (live_offsets.size() > 0 && $urandom_range(0, 99) < 85) begin
          idx = $urandom_range(0, live_offsets.size() - 1);
          off = live_offsets[idx];
          live_offsets.delete(idx);
        end else off = $urandom_range(0, 262143);
        send_item(KIND_FREE, $urandom_range(0, 262143), off);
      end
    end
    @(negedge clk);
    s_tvalid <= 0;

    // Drain outstanding results, then let the block settle
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (failures == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

FILE: sim.f
design/fha_pkg.sv
design/fha_mem.sv
design/fha_ctrl.sv
design/first_fit_heap_allocator.sv
design/fha_checker.sv
tb/first_fit_heap_allocator_checker.sv
tb/first_fit_heap_allocator_tb.sv
